// ----- rtl/ct_pkg.sv -----
// ----------------------------------------------------------------------------
// ct_pkg: shared types and constants for the columnar transposition block
// Grid geometry, pad byte, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package ct_pkg;

	localparam int NUM_COLS         = 5;
	localparam int COL_W            = 3;
	localparam int DEFAULT_MAX_ROWS = 12;
	localparam int CFG_INDEX_W      = 3;
	localparam int CFG_DATA_W       = COL_W;

	localparam logic [7:0] PAD_BYTE = 8'h78;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DECRYPT_MODE  = 3'd0,
		REG_FIRST_COLUMN  = 3'd1,
		REG_SECOND_COLUMN = 3'd2,
		REG_THIRD_COLUMN  = 3'd3,
		REG_FOURTH_COLUMN = 3'd4,
		REG_FIFTH_COLUMN  = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_WALK,
		ST_DRAIN
	} state_t;

endpackage

// ----- rtl/ct_if.sv -----
// ----------------------------------------------------------------------------
// ct_if: valid/ready channels of the columnar transposition block
// Input word carries one byte and its end flag; output word one result byte.
// ----------------------------------------------------------------------------
interface ct_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output end_of_message, input ready);
	modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface ct_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] result_byte;
	logic       end_of_run;
	logic       overflowed;

	modport source (output valid, output result_byte, output end_of_run, output overflowed,
		input ready);
	modport sink (input valid, input result_byte, input end_of_run, input overflowed,
		output ready);
endinterface

// ----- rtl/ct_store.sv -----
// ----------------------------------------------------------------------------
// ct_store: byte store of the transposition grid
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ct_store #(
	parameter int DEPTH = 60
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0]               rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/columnar_transposition.sv -----
// Bytes load one per cycle; after the final byte is accepted, the first result passes
// the store read register, the held-back word and the output register, later in decrypt when
// leading grid cells are pads. The run then walks 5*rows grid cells at one cell per cycle
// (store read port) while the output is not stalled; no new message is taken until it ends.
// Decrypt runs drop pad bytes, so fewer words than cells may come out.
// Reset: arst_n clears state, byte count, overflow flag and registers to their defaults.
// The store is not cleared; cells at or beyond the byte count read as pad.
// ----------------------------------------------------------------------------
// columnar_transposition: five-column transposition cipher
// Loads a message into the byte store, then emits it column-wise (encrypt) or
// refills the grid by keyed columns and emits row-wise without pads (decrypt).
// ----------------------------------------------------------------------------
module columnar_transposition import ct_pkg::*; #(
	parameter int MAX_ROWS = DEFAULT_MAX_ROWS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	ct_in_if.sink                  in_word,
	ct_out_if.source               out_word,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CAP = NUM_COLS * MAX_ROWS;
	localparam int AW  = $clog2(CAP + 1);
	localparam int IW  = $clog2(CAP);
	localparam int RW  = $clog2(MAX_ROWS + 1);

	localparam logic [AW-1:0]    CAP_A    = AW'(CAP);
	localparam logic [AW-1:0]    ROW_STEP = AW'(NUM_COLS);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(NUM_COLS - 1);
	localparam logic [COL_W-1:0] NCOL_C   = COL_W'(NUM_COLS);

	state_t state_q, state_d;

	logic             decrypt_q;
	logic [COL_W-1:0] order_q [NUM_COLS];

	logic [AW-1:0]    count_q;
	logic             ovf_q;
	logic [COL_W-1:0] colpos_q;
	logic [RW-1:0]    rows_q;

	logic [COL_W-1:0] cnt_a_q;
	logic [RW-1:0]    cnt_r_q;
	logic [AW-1:0]    rb_q;

	logic             v_s1;
	logic             force_s1;
	logic [7:0]       rdata;

	logic             pend_v_q;
	logic [7:0]       pend_q;

	logic             out_v_q;
	logic [7:0]       out_byte_q;
	logic             out_eor_q;
	logic             out_ovf_q;

	logic             accept_in, has_room, go, issue, finish;
	logic             row_last, col_last, walk_done;
	logic             found;
	logic [COL_W-1:0] kl;
	logic [COL_W-1:0] enc_col;
	logic [AW:0]      dec_pos, enc_addr, rd_addr, count_x;
	logic             force_x;
	logic [7:0]       cand;
	logic             keep;
	logic             out_load, out_last;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_q <= 1'b0;
			for (int k = 0; k < NUM_COLS; k++) begin
				order_q[k] <= COL_W'(k);
			end
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DECRYPT_MODE:  decrypt_q  <= cfg_data[0];
				REG_FIRST_COLUMN:  order_q[0] <= cfg_data;
				REG_SECOND_COLUMN: order_q[1] <= cfg_data;
				REG_THIRD_COLUMN:  order_q[2] <= cfg_data;
				REG_FOURTH_COLUMN: order_q[3] <= cfg_data;
				REG_FIFTH_COLUMN:  order_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_word.ready = (state_q == ST_LOAD);
	assign accept_in     = in_word.valid && in_word.ready;
	assign has_room      = count_q < CAP_A;
	assign go            = !out_v_q || out_word.ready;
	assign issue         = (state_q == ST_WALK) && go;
	assign finish        = (state_q == ST_DRAIN) && go && !v_s1;

	assign row_last  = cnt_r_q == (rows_q - RW'(1));
	assign col_last  = cnt_a_q == LAST_COL;
	// both walk orders end on the last row of the last column
	assign walk_done = row_last && col_last;

	// last order position naming the current grid column wins
	always_comb begin
		found = 1'b0;
		kl    = '0;
		for (int k = 0; k < NUM_COLS; k++) begin
			if (order_q[k] == cnt_a_q) begin
				found = 1'b1;
				kl    = COL_W'(k);
			end
		end
	end

	// encrypt walks order positions; the grid column comes from the key
	assign enc_col  = order_q[cnt_a_q];
	assign count_x  = (AW + 1)'(count_q);
	assign dec_pos  = (AW + 1)'(kl) * (AW + 1)'(rows_q) + (AW + 1)'(cnt_r_q);
	assign enc_addr = (AW + 1)'(rb_q) + (AW + 1)'(enc_col);
	assign rd_addr  = decrypt_q ? dec_pos : enc_addr;
	assign force_x  = decrypt_q ? (!found || dec_pos >= count_x)
	                            : (enc_col >= NCOL_C || enc_addr >= count_x);

	ct_store #(
		.DEPTH (CAP)
	) u_store (
		.clk   (clk),
		.we    (accept_in && has_room),
		.waddr (count_q[IW-1:0]),
		.wdata (in_word.data_byte),
		.re    (issue),
		.raddr (rd_addr[IW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:  if (accept_in && in_word.end_of_message) state_d = ST_WALK;
			ST_WALK:  if (issue && walk_done) state_d = ST_DRAIN;
			ST_DRAIN: if (finish) state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	// message fill bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			colpos_q <= '0;
			rows_q   <= '0;
		end else if (finish) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			colpos_q <= '0;
			rows_q   <= '0;
		end else if (accept_in) begin
			if (has_room) begin
				count_q  <= count_q + AW'(1);
				colpos_q <= (colpos_q == LAST_COL) ? '0 : colpos_q + COL_W'(1);
				if (colpos_q == '0) begin
					rows_q <= rows_q + RW'(1);
				end
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// walk counters: encrypt goes column-major, decrypt row-major
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q <= '0;
			cnt_r_q <= '0;
			rb_q    <= '0;
		end else if (accept_in && in_word.end_of_message) begin
			cnt_a_q <= '0;
			cnt_r_q <= '0;
			rb_q    <= '0;
		end else if (issue) begin
			if (!decrypt_q) begin
				if (row_last) begin
					cnt_r_q <= '0;
					rb_q    <= '0;
					cnt_a_q <= cnt_a_q + COL_W'(1);
				end else begin
					cnt_r_q <= cnt_r_q + RW'(1);
					rb_q    <= rb_q + ROW_STEP;
				end
			end else begin
				if (col_last) begin
					cnt_a_q <= '0;
					cnt_r_q <= cnt_r_q + RW'(1);
				end else begin
					cnt_a_q <= cnt_a_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (go) begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			force_s1 <= force_x;
		end
	end

	assign cand = force_s1 ? PAD_BYTE : rdata;
	assign keep = v_s1 && (!decrypt_q || cand != PAD_BYTE);

	// one word held back so the end-of-run flag lands on the true last word
	assign out_last = finish && pend_v_q;
	assign out_load = (go && keep && pend_v_q) || out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (go && keep) begin
			pend_v_q <= 1'b1;
		end else if (out_last) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && keep) begin
			pend_q <= cand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (out_word.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= pend_q;
			out_eor_q  <= out_last;
			out_ovf_q  <= ovf_q;
		end
	end

	assign out_word.valid       = out_v_q;
	assign out_word.result_byte = out_byte_q;
	assign out_word.end_of_run  = out_eor_q;
	assign out_word.overflowed  = out_ovf_q;

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_A)
		else $error("byte count beyond store capacity");

	a_no_read_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> !v_s1 && !pend_v_q)
		else $error("read pipeline busy while loading");

	a_clear_on_return: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD && $past(state_q) == ST_DRAIN |-> count_q == '0 && !ovf_q)
		else $error("message state not cleared after run");

	a_rows_nonzero_walk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> rows_q != '0 && cnt_r_q < rows_q)
		else $error("walk outside grid rows");

endmodule
